// ===== hdl/spd_pkg.sv =====
// Shared types and constants for the stereo ping-pong delay unit.
// No dependencies.
`default_nettype none

package spd_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int FB_W        = 15;
   localparam int MIX_W       = 16;
   localparam int GAIN_W      = 16;
   localparam int LEN_W       = 12;
   localparam int CSR_W       = 16;
   localparam int CSR_IDX_W   = 3;

   localparam int FB_SH  = 15;
   localparam int MIX_SH = 15;
   localparam int OUT_SH = 29;

   localparam logic [MIX_W-1:0] WET_FULL = MIX_W'(32768);

   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK_LEFT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK_RIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WET_MIX        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_LEFT      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_RIGHT     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_LEFT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_RIGHT   = 3'd6;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_left;
      logic signed [SAMPLE_BITS-1:0] sample_right;
   } spd_req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] out_left;
      logic signed [SAMPLE_BITS-1:0] out_right;
   } spd_rsp_type;

   // sequencing strobes from the top level to both channels
   typedef struct packed {
      logic clear;
      logic rd;
      logic mul;
      logic wb;
      logic load;
   } spd_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/spd_chan.sv =====
// One channel of the ping-pong delay: delay line memory, cursor and datapath.
// Depends on spd_pkg.
`default_nettype none

module spd_chan #(
   parameter int LINE_DEPTH = 2048
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  spd_pkg::spd_ctl_type                     ctl,
   input  logic [$clog2(LINE_DEPTH)-1:0]            clr_addr,
   input  logic signed [spd_pkg::SAMPLE_BITS-1:0]   sample,
   input  logic signed [spd_pkg::SAMPLE_BITS-1:0]   other_old,
   input  logic [spd_pkg::FB_W-1:0]                 feedback,
   input  logic [spd_pkg::MIX_W-1:0]                wet_mix,
   input  logic [spd_pkg::GAIN_W-1:0]               gain,
   input  logic [spd_pkg::LEN_W-1:0]                length,
   output logic signed [spd_pkg::SAMPLE_BITS-1:0]   old_sample,
   output logic signed [spd_pkg::SAMPLE_BITS-1:0]   result
);
   import spd_pkg::*;

   localparam int SB     = SAMPLE_BITS;
   localparam int ADDR_W = $clog2(LINE_DEPTH);
   localparam int CNT_W  = ADDR_W + 1;
   localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int DF_W   = SB + 1;
   localparam int WP_W   = DF_W + MIX_W + 1;
   localparam int BL_W   = SB + MIX_W;
   localparam int FP_W   = SB + FB_W + 1;
   localparam int FR_W   = FP_W + 1;
   localparam int PR_W   = BL_W + GAIN_W + 1;

   localparam logic signed [SB-1:0] SAT_HI = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] SAT_LO = {1'b1, {(SB-1){1'b0}}};

   logic signed [SB-1:0] mem [LINE_DEPTH];

   logic signed [SB-1:0]   in_ff;
   logic signed [SB-1:0]   rd_data_ff;
   logic [ADDR_W-1:0]      cursor_ff, cursor_in;
   logic signed [FP_W-1:0] fbp_ff, fbp_in;
   logic signed [BL_W-1:0] blend_ff, blend_in;
   logic signed [PR_W-1:0] prod_ff, prod_in;
   logic signed [SB-1:0]   result_ff, result_in;

   logic [MIX_W-1:0]       w_eff;
   logic signed [DF_W-1:0] diff;
   logic signed [WP_W-1:0] wprod, blend_sum;
   logic signed [FR_W-1:0] fb_round, wr_sum;
   logic signed [SB-1:0]   wr_val;
   logic signed [PR_W-1:0] out_round;
   logic [CMP_W-1:0]       len_ext, len_eff, cur_next;

   // multiply stage
   always_comb begin
      w_eff     = (wet_mix > WET_FULL) ? WET_FULL : wet_mix;
      diff      = DF_W'(rd_data_ff) - DF_W'(in_ff);
      wprod     = diff * $signed({1'b0, w_eff});
      blend_sum = (WP_W'(in_ff) <<< MIX_SH) + wprod;
      blend_in  = blend_sum[BL_W-1:0];
      fbp_in    = other_old * $signed({1'b0, feedback});
   end

   // write-back stage
   always_comb begin
      fb_round = (FR_W'(fbp_ff) + (FR_W'(1) <<< (FB_SH-1))) >>> FB_SH;
      wr_sum   = FR_W'(in_ff) + fb_round;
      if (wr_sum > FR_W'(SAT_HI)) begin
         wr_val = SAT_HI;
      end else if (wr_sum < FR_W'(SAT_LO)) begin
         wr_val = SAT_LO;
      end else begin
         wr_val = wr_sum[SB-1:0];
      end
      prod_in = blend_ff * $signed({1'b0, gain});

      len_ext = CMP_W'(length);
      if (len_ext == '0) begin
         len_eff = CMP_W'(1);
      end else if (len_ext > CMP_W'(LINE_DEPTH)) begin
         len_eff = CMP_W'(LINE_DEPTH);
      end else begin
         len_eff = len_ext;
      end
      cur_next = CMP_W'(cursor_ff) + CMP_W'(1);
      if (!ctl.wb) begin
         cursor_in = cursor_ff;
      end else if (cur_next >= len_eff) begin
         cursor_in = '0;
      end else begin
         cursor_in = cur_next[ADDR_W-1:0];
      end
   end

   // result stage
   always_comb begin
      out_round = (prod_ff + (PR_W'(1) <<< (OUT_SH-1))) >>> OUT_SH;
      if (out_round > PR_W'(SAT_HI)) begin
         result_in = SAT_HI;
      end else if (out_round < PR_W'(SAT_LO)) begin
         result_in = SAT_LO;
      end else begin
         result_in = out_round[SB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         mem[clr_addr] <= '0;
      end else if (ctl.wb) begin
         mem[cursor_ff] <= wr_val;
      end
      if (ctl.rd) begin
         rd_data_ff <= mem[cursor_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
      end else begin
         cursor_ff <= cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd) begin
         in_ff <= sample;
      end
      if (ctl.mul) begin
         fbp_ff   <= fbp_in;
         blend_ff <= blend_in;
      end
      if (ctl.wb) begin
         prod_ff <= prod_in;
      end
      if (ctl.load) begin
         result_ff <= result_in;
      end
   end

   assign old_sample = rd_data_ff;
   assign result     = result_ff;

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(cursor_ff) < CNT_W'(LINE_DEPTH))
      else $error("cursor beyond line depth");

   a_cursor_step: assert property (@(posedge clock) disable iff (reset)
      ctl.wb |=> (cursor_ff == '0 || cursor_ff == $past(cursor_ff) + 1'b1))
      else $error("cursor did not advance or wrap");

   a_cursor_hold: assert property (@(posedge clock) disable iff (reset)
      !ctl.wb |=> $stable(cursor_ff))
      else $error("cursor moved outside write-back");

endmodule

`default_nettype wire

// ===== hdl/stereo_ping_pong_delay_unit.sv =====
// Top level of the stereo ping-pong delay: handshakes, registers, sequencer.
// Depends on spd_pkg and spd_chan.
//
// After reset the unit zeroes both delay lines, one entry per cycle, with
// req_ready held low for the whole pass; register writes are taken during
// that pass. Each stereo item then goes through these steps in order: the
// accepting cycle reads both lines, then multiply, write-back with gain
// multiply, and rounding into the result register. No new item is taken
// until the last one is loaded into the result register. The line memories
// are read through a data register, and the gain multiply depends on the
// blend multiply ahead of rounding. A finished result may wait in the result
// register while the next item is accepted and processed; the sequencer
// stalls at its last step only while that register is full.
`default_nettype none

module stereo_ping_pong_delay_unit #(
   parameter int LINE_DEPTH = 2048
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  spd_pkg::spd_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output spd_pkg::spd_rsp_type               rsp_data,
   input  logic                               csr_wr_en,
   input  logic [spd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [spd_pkg::CSR_W-1:0]          csr_wdata
);
   import spd_pkg::*;

   localparam int ADDR_W = $clog2(LINE_DEPTH);

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_CLEAR = 3'd0;
   localparam logic [ST_W-1:0] ST_IDLE  = 3'd1;
   localparam logic [ST_W-1:0] ST_MUL   = 3'd2;
   localparam logic [ST_W-1:0] ST_WB    = 3'd3;
   localparam logic [ST_W-1:0] ST_OUT   = 3'd4;

   logic [ST_W-1:0]   state_ff, state_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [FB_W-1:0]   fb_left_ff, fb_right_ff;
   logic [MIX_W-1:0]  wet_mix_ff;
   logic [GAIN_W-1:0] gain_left_ff, gain_right_ff;
   logic [LEN_W-1:0]  len_left_ff, len_right_ff;

   spd_ctl_type       ctl;
   logic              accept;
   logic signed [SAMPLE_BITS-1:0] old_l, old_r, res_l, res_r;

   assign accept = req_valid && req_ready;

   always_comb begin
      ctl.clear = (state_ff == ST_CLEAR);
      ctl.rd    = accept;
      ctl.mul   = (state_ff == ST_MUL);
      ctl.wb    = (state_ff == ST_WB);
      ctl.load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(LINE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_WB;
         ST_WB:  state_in = ST_OUT;
         ST_OUT: begin
            if (ctl.load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase

      if (ctl.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_left_ff    <= FB_W'(16384);
         fb_right_ff   <= FB_W'(16384);
         wet_mix_ff    <= MIX_W'(16384);
         gain_left_ff  <= GAIN_W'(16384);
         gain_right_ff <= GAIN_W'(16384);
         len_left_ff   <= LEN_W'(1024);
         len_right_ff  <= LEN_W'(1024);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FEEDBACK_LEFT:  fb_left_ff    <= csr_wdata[FB_W-1:0];
            CSR_FEEDBACK_RIGHT: fb_right_ff   <= csr_wdata[FB_W-1:0];
            CSR_WET_MIX:        wet_mix_ff    <= csr_wdata[MIX_W-1:0];
            CSR_GAIN_LEFT:      gain_left_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_RIGHT:     gain_right_ff <= csr_wdata[GAIN_W-1:0];
            CSR_LENGTH_LEFT:    len_left_ff   <= csr_wdata[LEN_W-1:0];
            CSR_LENGTH_RIGHT:   len_right_ff  <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   spd_chan #(.LINE_DEPTH(LINE_DEPTH)) u_chan_left (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .clr_addr   (clr_cnt_ff),
      .sample     (req_data.sample_left),
      .other_old  (old_r),
      .feedback   (fb_left_ff),
      .wet_mix    (wet_mix_ff),
      .gain       (gain_left_ff),
      .length     (len_left_ff),
      .old_sample (old_l),
      .result     (res_l)
   );

   spd_chan #(.LINE_DEPTH(LINE_DEPTH)) u_chan_right (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .clr_addr   (clr_cnt_ff),
      .sample     (req_data.sample_right),
      .other_old  (old_l),
      .feedback   (fb_right_ff),
      .wet_mix    (wet_mix_ff),
      .gain       (gain_right_ff),
      .length     (len_right_ff),
      .old_sample (old_r),
      .result     (res_r)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_data.out_left  = res_l;
      rsp_data.out_right = res_r;
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_MUL)
      else $error("accepted item did not enter multiply step");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside result step");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && !rsp_ready) |=> state_ff == ST_OUT)
      else $error("result step left while result register full");

   a_clear_no_item: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready && !rsp_valid_ff)
      else $error("handshake active during line clearing");

endmodule

`default_nettype wire
